// ===== hw/rtl/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, round constants, initial hash values and round functions.
// ----------------------------------------------------------------------------
package sha_pkg;

	// one classified request held in the front queue
	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       last;
	} req_t;

	// commands from the sequencer to the compression unit
	typedef struct packed {
		logic start;
		logic init;
	} core_cmd_t;

	typedef logic [15:0][31:0] block_t;
	typedef logic [7:0][31:0]  hash_t;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	localparam logic [31:0] INIT_H [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
		input logic [31:0] g);
		choose = (e & f) ^ (~e & g);
	endfunction

	function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
		input logic [31:0] c);
		majority = (a & b) ^ (a & c) ^ (b & c);
	endfunction

endpackage

// ===== hw/rtl/sha_front.sv =====
// ----------------------------------------------------------------------------
// SHA-256 front end
// Accepts input requests, drops idle ones and queues the rest for the back end.
// ----------------------------------------------------------------------------
module sha_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] data_byte
	input  logic              s_tuser,   // [0] byte_present
	input  logic              s_tlast,   // message_end
	output logic              q_valid,
	output sha_pkg::req_t     q_req,
	input  logic              q_pop
);

	sha_pkg::req_t  fifo_q [4];
	logic [1:0]     wr_ptr_q;
	logic [1:0]     rd_ptr_q;
	logic [2:0]     count_q;
	logic           push;
	logic           take;

	// accept while there is room; only requests that carry work enter the queue
	assign s_tready = (count_q != 3'd4);
	assign take     = s_tvalid & s_tready;
	assign push     = take & (s_tuser | s_tlast);
	assign q_valid  = (count_q != 3'd0);
	assign q_req    = fifo_q[rd_ptr_q];

	// store the entry
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{data: s_tdata, present: s_tuser, last: s_tlast};
		end
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 2'd1;
			if (q_pop) rd_ptr_q <= rd_ptr_q + 2'd1;
			count_q <= count_q + {2'b00, push} - {2'b00, q_pop};
		end
	end

`ifndef SYNTHESIS
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty request queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4) else $error("request queue overfilled");
	a_idle_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		take && !s_tuser && !s_tlast |=> count_q <= $past(count_q))
		else $error("idle request entered the queue");
`endif

endmodule

// ===== hw/rtl/sha_round.sv =====
// ----------------------------------------------------------------------------
// SHA-256 compression unit
// Holds the chaining words; runs 64 rounds, one per cycle, then a final add.
// ----------------------------------------------------------------------------
module sha_round (
	input  logic                clk,
	input  logic                arst_n,
	input  sha_pkg::core_cmd_t  cmd,
	input  sha_pkg::block_t     blk,
	output logic                busy,
	output sha_pkg::hash_t      hash
);

	logic [31:0]  h_q [8];
	logic [31:0]  v_q [8];
	logic [31:0]  w_q [16];
	logic [5:0]   round_q;
	logic         run_q;
	logic         fin_q;
	logic [31:0]  t1;
	logic [31:0]  t2;
	logic [31:0]  w_new;

	assign busy = run_q | fin_q;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			hash[i] = h_q[i];
		end
	end

	// round datapath
	always_comb begin
		t1 = v_q[7] + sha_pkg::big_sigma1(v_q[4]) + sha_pkg::choose(v_q[4], v_q[5], v_q[6])
			+ sha_pkg::ROUND_K[round_q] + w_q[0];
		t2 = sha_pkg::big_sigma0(v_q[0]) + sha_pkg::majority(v_q[0], v_q[1], v_q[2]);
		w_new = w_q[0] + sha_pkg::small_sigma0(w_q[1]) + w_q[9]
			+ sha_pkg::small_sigma1(w_q[14]);
	end

	// working variables and schedule window
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
			for (int i = 0; i < 16; i++) w_q[i] <= blk[i];
		end else if (run_q) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= w_new;
		end
	end

	// round control and chaining update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::INIT_H[i];
			round_q <= '0;
			run_q   <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			if (cmd.start) begin
				run_q   <= 1'b1;
				round_q <= '0;
			end else if (run_q) begin
				round_q <= round_q + 6'd1;
				if (round_q == 6'd63) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
			if (fin_q) begin
				fin_q <= 1'b0;
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
			end else if (cmd.init) begin
				for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::INIT_H[i];
			end
		end
	end

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !busy) else $error("compression started while busy");
	a_run_fin_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(run_q && fin_q)) else $error("round and final add overlap");
	a_fin_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(fin_q) |-> $past(round_q) == 6'd63) else $error("final add out of order");
`endif

endmodule

// ===== hw/rtl/sha_back.sv =====
// ----------------------------------------------------------------------------
// SHA-256 back end
// Builds blocks from queued bytes, pads the message, drives the compression
// unit and emits the digest words.
// ----------------------------------------------------------------------------
module sha_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  sha_pkg::req_t       q_req,
	output logic                q_pop,
	output sha_pkg::core_cmd_t  core_cmd,
	output sha_pkg::block_t     core_blk,
	input  logic                core_busy,
	input  sha_pkg::hash_t      core_hash,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [39:0]         m_tdata,   // [31:0] digest_word, [34:32] word_number
	output logic                m_tlast    // final_word
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_PADC = 3'd2;
	localparam logic [2:0] ST_LEN  = 3'd3;
	localparam logic [2:0] ST_WAIT = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]       state_q;
	logic [5:0]       cnt_q;
	logic [63:0]      bits_q;
	logic [2:0]       idx_q;
	sha_pkg::block_t  buf_q;
	sha_pkg::block_t  buf_wr;
	sha_pkg::block_t  buf_pad;
	sha_pkg::block_t  buf_len;
	logic             need_core;
	logic             wrap;
	logic             out_done;

	// a request that ends a block or the message needs the compression unit free
	assign wrap      = q_req.present & (cnt_q == 6'd63);
	assign need_core = q_req.last | wrap;
	assign q_pop     = (state_q == ST_IDLE) & q_valid & (~need_core | ~core_busy);
	assign out_done  = m_tvalid & m_tready & (idx_q == 3'd7);

	// buffer after the byte write, after padding, and with the length appended
	always_comb begin
		logic [5:0] p;
		buf_wr = buf_q;
		buf_wr[cnt_q[5:2]][{~cnt_q[1:0], 3'b000} +: 8] = q_req.data;
		buf_pad = buf_q;
		for (int w = 0; w < 16; w++) begin
			for (int b = 0; b < 4; b++) begin
				p = 6'(w * 4 + b);
				if (p == cnt_q) buf_pad[w][(3 - b) * 8 +: 8] = sha_pkg::PAD_BYTE;
				else if (p > cnt_q) buf_pad[w][(3 - b) * 8 +: 8] = 8'h00;
			end
		end
		buf_len = buf_q;
		buf_len[14] = bits_q[63:32];
		buf_len[15] = bits_q[31:0];
	end

	// compression requests
	always_comb begin
		core_cmd.start = 1'b0;
		core_cmd.init  = out_done;
		core_blk       = buf_wr;
		unique case (state_q)
			ST_IDLE: core_cmd.start = q_pop & wrap;
			ST_PADC: begin
				core_cmd.start = ~core_busy;
				core_blk       = buf_q;
			end
			ST_LEN: begin
				core_cmd.start = ~core_busy;
				core_blk       = buf_len;
			end
			default: core_cmd.start = 1'b0;
		endcase
	end

	// block buffer
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_pop && q_req.present) begin
			buf_q <= buf_wr;
		end else if (state_q == ST_PAD) begin
			buf_q <= buf_pad;
		end else if (state_q == ST_PADC && !core_busy) begin
			buf_q <= '0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			bits_q  <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						if (q_req.present) begin
							cnt_q  <= cnt_q + 6'd1;
							bits_q <= bits_q + 64'd8;
						end
						if (q_req.last) state_q <= ST_PAD;
					end
				end
				ST_PAD: begin
					state_q <= (cnt_q >= 6'd56) ? ST_PADC : ST_LEN;
				end
				ST_PADC: begin
					if (!core_busy) state_q <= ST_LEN;
				end
				ST_LEN: begin
					if (!core_busy) state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (!core_busy) begin
						state_q <= ST_OUT;
						idx_q   <= '0;
					end
				end
				ST_OUT: begin
					if (m_tvalid && m_tready) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							state_q <= ST_IDLE;
							cnt_q   <= '0;
							bits_q  <= '0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// digest words straight from the chaining registers
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {5'b00000, idx_q, core_hash[idx_q]};
	assign m_tlast  = (idx_q == 3'd7);

`ifndef SYNTHESIS
	a_bits_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		bits_q[8:3] == cnt_q && bits_q[2:0] == 3'd0)
		else $error("bit length out of step with byte count");
	a_one_digest: assert property (@(posedge clk) disable iff (!arst_n)
		out_done |=> !m_tvalid) else $error("digest emitted past last word");
	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !q_pop && !core_busy) else $error("digest shown while working");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(idx_q))
		else $error("digest word dropped under stall");
`endif

endmodule

// ===== hw/rtl/sha256_hash.sv =====
// ----------------------------------------------------------------------------
// SHA-256 streaming hash
// Hashes a byte stream and returns the eight digest words of each message.
// ----------------------------------------------------------------------------
// Input channel (s_*): one request per handshake. s_tdata carries a byte,
// s_tuser says the byte belongs to the message, s_tlast closes the message
// (its byte, if flagged, is taken first). A request with neither flag is
// dropped. Requests pass through a four-entry queue, so the input keeps
// flowing while a block is compressed.
// Output channel (m_*): eight words per message, word 0 (most significant)
// first; m_tlast marks word 7. The words hold until taken, and a stall on the
// output holds the sequencer while the queue keeps filling.
// Throughput: one byte per cycle, except while a message is padded or its
// digest is output, or while a full block waits for the compression unit.
// Each 64-byte block runs 64 rounds and a final add, overlapped with intake
// of the next block. After the end request the block is padded (spilling
// into a second block if needed), the length block is compressed, and
// word 0 follows the final add, later if requests wait or a block is busy.
// Reset: chaining words go to the initial hash values, counts clear, the
// queue empties. After word 7 the block is ready for the next message.
// ----------------------------------------------------------------------------
module sha256_hash (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tuser,   // [0] byte_present
	input  logic         s_tlast,   // message_end
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [39:0]  m_tdata,   // [31:0] digest_word, [34:32] word_number
	output logic         m_tlast    // final_word
);

	logic                q_valid;
	logic                q_pop;
	sha_pkg::req_t       q_req;
	sha_pkg::core_cmd_t  core_cmd;
	sha_pkg::block_t     core_blk;
	sha_pkg::hash_t      core_hash;
	logic                core_busy;

	// accept and queue requests
	sha_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.q_valid  (q_valid),
		.q_req    (q_req),
		.q_pop    (q_pop)
	);

	// block assembly, padding and digest output
	sha_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_req     (q_req),
		.q_pop     (q_pop),
		.core_cmd  (core_cmd),
		.core_blk  (core_blk),
		.core_busy (core_busy),
		.core_hash (core_hash),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// compression rounds
	sha_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (core_cmd),
		.blk    (core_blk),
		.busy   (core_busy),
		.hash   (core_hash)
	);

endmodule
